/* rtl/core/random_insert_pool_queue_defines.svh */
// Assertion macros used by the checker of the random insert pool queue.
`ifndef RANDOM_INSERT_POOL_QUEUE_DEFINES_SVH
`define RANDOM_INSERT_POOL_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RIPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RIPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ripq_pkg.sv */
package ripq_pkg;

    localparam int RND_W  = 16;
    localparam int VAL_W  = 8;
    localparam int CNT_OUT_W = 7;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_SHIFT,
        ST_WRITE,
        ST_TAKE,
        ST_DONE
    } ripq_state_t;

endpackage

/* rtl/core/ripq_ram.sv */
module ripq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/random_insert_pool_queue.sv */
// Ordered pool of up to CAPACITY byte entries kept as a ring in one memory with one write
// port and one registered read port. An add reduces random_value modulo (count + 1) one
// quotient bit per cycle, then moves each entry from the back down to that place back by one
// place (up to CAPACITY - 1 entries, overlapping read and write of the shift), then writes
// the new entry into the freed place. A take reads the front entry; a rejected item goes
// straight to its result. Items are handled one at a time, and a finished result sits in an
// output register while the next item is taken in. The memory needs no clearing after reset
// since only entries below the count are ever read.
module random_insert_pool_queue
    import ripq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // entry_value [7:0], random_value [23:8]
    input  logic        s_axis_tuser,  // action [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // taken_value [7:0], entry_count [14:8], single_left [15]
    output logic [1:0]  m_axis_tuser   // status [1:0]
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(RND_W);
    localparam int DEPTH = 1 << AW;

    ripq_state_t state_reg, state_next;

    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [RND_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    div_reg, div_next;
    logic [SW-1:0]    step_reg, step_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [AW-1:0]    last_reg, last_next;
    logic             more_reg, more_next;
    logic             pend_reg, pend_next;
    logic [VAL_W-1:0] res_taken_reg, res_taken_next;
    logic [1:0]       res_status_reg, res_status_next;

    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_data_reg, out_data_next;
    logic [1:0]       out_user_reg, out_user_next;

    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [VAL_W-1:0] ram_wr_data;
    logic [AW-1:0]    ram_rd_addr;
    logic [VAL_W-1:0] ram_rd_data;

    logic [CW:0]      div_shifted;
    logic [CW:0]      div_diff;
    logic [CW-1:0]    rem_step;
    logic [CW+6:0]    count_ext;

    // One restoring step of the remainder: bring down the next dividend bit and subtract
    // the divisor where it fits.
    assign div_shifted = {rem_reg, quo_reg[RND_W-1]};
    assign div_diff    = div_shifted - {1'b0, div_reg};
    assign rem_step    = div_diff[CW] ? div_shifted[CW-1:0] : div_diff[CW-1:0];

    assign count_ext = {{CNT_OUT_W{1'b0}}, count_reg};

    ripq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        step_reg       <= step_next;
        pos_reg        <= pos_next;
        src_reg        <= src_next;
        last_reg       <= last_next;
        res_taken_reg  <= res_taken_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        val_next        = val_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        pos_next        = pos_reg;
        src_next        = src_reg;
        last_next       = last_reg;
        more_next       = more_reg;
        pend_next       = pend_reg;
        res_taken_next  = res_taken_reg;
        res_status_next = res_status_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_valid_next  = out_valid_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = head_reg + last_reg + AW'(1);
        ram_wr_data = ram_rd_data;
        ram_rd_addr = head_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    val_next        = s_axis_tdata[VAL_W-1:0];
                    quo_next        = s_axis_tdata[VAL_W+RND_W-1:VAL_W];
                    rem_next        = '0;
                    step_next       = '0;
                    div_next        = count_reg + CW'(1);
                    res_taken_next  = '0;
                    res_status_next = STATUS_OK;
                    if (s_axis_tuser == ACT_TAKE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            // The front entry is being read at this edge.
                            state_next = ST_TAKE;
                        end
                    end
                    else if (count_reg == CW'(CAPACITY))
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next  = rem_step;
                quo_next  = quo_reg << 1;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(RND_W - 1))
                begin
                    pos_next  = rem_step[AW-1:0];
                    src_next  = count_reg[AW-1:0] - AW'(1);
                    more_next = 1'b1;
                    pend_next = 1'b0;
                    if (rem_step == count_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                // Each cycle reads one entry and writes back the one read in the cycle before,
                // one place further from the front.
                if (pend_reg)
                begin
                    ram_wr_en = 1'b1;
                end
                if (more_reg)
                begin
                    ram_rd_addr = head_reg + src_reg;
                    last_next   = src_reg;
                    pend_next   = 1'b1;
                    if (src_reg == pos_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        src_next = src_reg - AW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = head_reg + pos_reg;
                ram_wr_data = val_reg;
                count_next  = count_reg + CW'(1);
                state_next  = ST_DONE;
            end

            ST_TAKE:
            begin
                res_taken_next = ram_rd_data;
                head_next      = head_reg + AW'(1);
                count_next     = count_reg - CW'(1);
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {(count_reg == CW'(1)), count_ext[CNT_OUT_W-1:0],
                                      res_taken_reg};
                    out_user_next  = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* rtl/core/ripq_checker.sv */
`include "random_insert_pool_queue_defines.svh"

module ripq_checker
    import ripq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result must stay offered unchanged.
    `RIPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // Only a successful take carries a value.
    `RIPQ_ASSERT_IMPL(a_taken_zero, m_axis_tvalid && m_axis_tuser != STATUS_OK, m_axis_tdata[7:0] == 8'd0, "value returned on a rejected item")

    // A take from an empty pool leaves the pool empty.
    `RIPQ_ASSERT_IMPL(a_empty_count, m_axis_tvalid && m_axis_tuser == STATUS_EMPTY, m_axis_tdata[14:8] == 7'd0, "empty take reports entries held")

    // The single-entry flag agrees with the reported count.
    `RIPQ_ASSERT_IMPL(a_single_left, m_axis_tvalid && m_axis_tdata[15], m_axis_tdata[14:8] == 7'd1, "single entry flag without a count of one")

    // No status code beyond the full-pool one is ever produced.
    `RIPQ_ASSERT_IMPL(a_status_code, m_axis_tvalid, m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_EMPTY || m_axis_tuser == STATUS_FULL, "undefined status code")

endmodule

bind random_insert_pool_queue ripq_checker u_ripq_checker (.*);
